/* src/spq_pkg.sv */
package spq_pkg;

    localparam logic FUNC_ENQ = 1'b0;
    localparam logic FUNC_DEQ = 1'b1;

    localparam int OCC_W = 5;

    typedef struct packed {
        logic               func;
        logic signed [31:0] in_value;
        logic signed [31:0] in_weight;
    } t_req;

    typedef struct packed {
        logic               out_valid;
        logic signed [31:0] out_value;
        logic signed [31:0] out_weight;
        logic               dropped;
        logic [OCC_W-1:0]   occupancy;
    } t_rsp;

    // what one cell shows its neighbors
    typedef struct packed {
        logic signed [31:0] weight;
        logic signed [31:0] value;
        logic               gt;
    } t_link;

    // operation broadcast to every cell
    typedef struct packed {
        logic               enq;
        logic               deq;
        logic signed [31:0] weight;
        logic signed [31:0] value;
    } t_cmd;

endpackage

/* src/spq_chan_if.sv */
interface spq_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* src/stable_min_priority_queue_core.sv */
// stable min priority queue
// i_req carries words {func, in_value, in_weight}: func 0 enqueues, 1 dequeues.
// o_rsp carries one word per request: {out_valid, out_value, out_weight,
// dropped, occupancy}, occupancy being the entry count after the request.
// entries live in a row of CAPACITY cells kept sorted by signed weight; an
// enqueue shifts every heavier entry one cell up and drops the new one in the
// gap, so equal weights leave in arrival order; a dequeue shifts the row down.
// the response is registered and shows in the cycle after acceptance.
// throughput: one request per cycle while the receiver takes the responses; all
// cells compare against the incoming weight in parallel, so one shift per request sets the rate.
// an enqueue while full leaves the store untouched and reports dropped;
// a dequeue while empty reports out_valid low with zero value and weight.
// reset empties the queue at once; cell contents are not cleared.
// when the receiver stalls the response register holds, and i_req.ready drops
// until it is taken; a request can be accepted in the cycle it is taken.
module stable_min_priority_queue_core #(
    parameter int CAPACITY = 16
) (
    input logic       i_clk,
    input logic       i_rst_n,
    spq_chan_if.sink   i_req,
    spq_chan_if.source o_rsp
);
    import spq_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    t_rsp          r_out;
    t_rsp          n_out;
    logic          r_out_vld;
    logic          acc;
    logic          full;
    logic          empty;
    t_req          req;
    t_cmd          cmd;
    t_link         links [CAPACITY];

    assign req         = i_req.payload;
    assign i_req.ready = !r_out_vld || o_rsp.ready;
    assign acc         = i_req.valid && i_req.ready;
    assign full        = (r_count == CW'(CAPACITY));
    assign empty       = (r_count == '0);

    assign cmd.enq    = acc && (req.func == FUNC_ENQ) && !full;
    assign cmd.deq    = acc && (req.func == FUNC_DEQ) && !empty;
    assign cmd.weight = req.in_weight;
    assign cmd.value  = req.in_value;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_link prev;
        t_link next;
        if (g == 0) begin : g_first
            assign prev = '0;
        end else begin : g_mid
            assign prev = links[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign next = '0;
        end else begin : g_up
            assign next = links[g+1];
        end
        spq_cell u_cell (
            .i_clk  (i_clk),
            .i_occ  (CW'(g) < r_count),
            .i_cmd  (cmd),
            .i_prev (prev),
            .i_next (next),
            .o_link (links[g])
        );
    end

    always_comb begin
        n_count = r_count;
        if (cmd.enq) begin
            n_count = r_count + 1'b1;
        end else if (cmd.deq) begin
            n_count = r_count - 1'b1;
        end
        n_out            = '0;
        n_out.out_valid  = cmd.deq;
        n_out.out_value  = cmd.deq ? links[0].value : '0;
        n_out.out_weight = cmd.deq ? links[0].weight : '0;
        n_out.dropped    = (req.func == FUNC_ENQ) && full;
        n_out.occupancy  = OCC_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_count <= n_count;
            if (acc) begin
                r_out_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
        end
        if (acc) begin
            r_out <= n_out;
        end
    end

    assign o_rsp.valid   = r_out_vld;
    assign o_rsp.payload = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_deq_reports: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && (req.func == FUNC_DEQ) && !empty |=> r_out.out_valid)
        else $error("dequeue of a stored entry not reported");

    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out.dropped |-> full)
        else $error("drop reported while not full");

    a_count_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !acc |=> r_count == $past(r_count))
        else $error("entry count moved without a request");

endmodule

/* src/spq_cell.sv */
module spq_cell (
    input  logic           i_clk,
    input  logic           i_occ,
    input  spq_pkg::t_cmd  i_cmd,
    input  spq_pkg::t_link i_prev,
    input  spq_pkg::t_link i_next,
    output spq_pkg::t_link o_link
);
    import spq_pkg::*;

    logic signed [31:0] r_weight;
    logic signed [31:0] r_value;
    logic signed [31:0] n_weight;
    logic signed [31:0] n_value;
    logic               gt;

    assign gt = i_occ && (r_weight > i_cmd.weight);

    always_comb begin
        n_weight = r_weight;
        n_value  = r_value;
        if (i_cmd.enq) begin
            if (i_prev.gt) begin
                n_weight = i_prev.weight;
                n_value  = i_prev.value;
            end else if (gt || !i_occ) begin
                n_weight = i_cmd.weight;
                n_value  = i_cmd.value;
            end
        end else if (i_cmd.deq) begin
            n_weight = i_next.weight;
            n_value  = i_next.value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_weight <= n_weight;
        r_value  <= n_value;
    end

    assign o_link.weight = r_weight;
    assign o_link.value  = r_value;
    assign o_link.gt     = gt;

endmodule
